// File: rtl/hptw_pkg.sv
`timescale 1ns / 1ps

package hptw_pkg;

  localparam int OFFSET_BITS  = 4;
  localparam int TABLE_LEVELS = 2;
  localparam int FRAME_COUNT  = 16;
  localparam int WORD_BITS    = 32;

  localparam int PAGE_WORDS  = 1 << OFFSET_BITS;
  localparam int PAGE_BITS   = OFFSET_BITS * TABLE_LEVELS;
  localparam int PAGE_COUNT  = 1 << PAGE_BITS;
  localparam int VA_BITS     = OFFSET_BITS * (TABLE_LEVELS + 1);
  localparam int VIRT_WORDS  = 1 << VA_BITS;
  localparam int FRAME_BITS  = $clog2(FRAME_COUNT);
  localparam int FA_BITS     = FRAME_BITS + OFFSET_BITS;
  localparam int FRAME_WORDS = FRAME_COUNT * PAGE_WORDS;
  localparam int LVL_BITS    = $clog2(TABLE_LEVELS + 1);
  localparam int STK_BITS    = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;
  localparam int CNT_BITS    = OFFSET_BITS + 1;
  localparam int DIST_BITS   = PAGE_BITS + 1;

  localparam int ADDR_W    = 32;
  localparam int DATA_W    = 32;
  localparam int PA_W      = 8;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 40;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_T_RD,
    CMD_T_NEXT,
    CMD_S_INIT,
    CMD_S_RD,
    CMD_S_POP,
    CMD_S_SKIP,
    CMD_S_LEAF,
    CMD_S_PUSH,
    CMD_E_RD,
    CMD_E_NEXT,
    CMD_E_TAKE,
    CMD_P_TOP,
    CMD_CNT_CLR,
    CMD_V_RD,
    CMD_V_WR,
    CMD_V_END,
    CMD_Z_WR,
    CMD_R_RD,
    CMD_R_WR,
    CMD_LINK,
    CMD_A_WR,
    CMD_A_RD,
    CMD_OUT
  } dp_cmd_e;

  typedef struct packed {
    logic in_oor;
    logic rd_zero;
    logic last_lvl;
    logic idx_end;
    logic cnt_end;
    logic depth_zero;
    logic leaf_depth;
    logic avoid_hit;
    logic top_small;
    logic swap_hit;
    logic is_write;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/hptw_ctrl.sv
`timescale 1ns / 1ps

module hptw_ctrl import hptw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_e cmd_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_T_RD   = 5'd1;
  localparam logic [4:0] ST_T_CHK  = 5'd2;
  localparam logic [4:0] ST_S_RD   = 5'd3;
  localparam logic [4:0] ST_S_CHK  = 5'd4;
  localparam logic [4:0] ST_E_RD   = 5'd5;
  localparam logic [4:0] ST_E_CHK  = 5'd6;
  localparam logic [4:0] ST_P_TOP  = 5'd7;
  localparam logic [4:0] ST_V_RD   = 5'd8;
  localparam logic [4:0] ST_V_WR   = 5'd9;
  localparam logic [4:0] ST_P_INIT = 5'd10;
  localparam logic [4:0] ST_Z_WR   = 5'd11;
  localparam logic [4:0] ST_R_RD   = 5'd12;
  localparam logic [4:0] ST_R_WR   = 5'd13;
  localparam logic [4:0] ST_LINK   = 5'd14;
  localparam logic [4:0] ST_ACC    = 5'd15;
  localparam logic [4:0] ST_DONE   = 5'd16;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = sts_i.in_oor ? ST_DONE : ST_T_RD;
        end
      end
      ST_T_RD: begin
        cmd_o   = CMD_T_RD;
        state_d = ST_T_CHK;
      end
      ST_T_CHK: begin
        if (!sts_i.rd_zero) begin
          cmd_o   = CMD_T_NEXT;
          state_d = sts_i.last_lvl ? ST_ACC : ST_T_RD;
        end else begin
          cmd_o   = CMD_S_INIT;
          state_d = ST_S_RD;
        end
      end
      ST_S_RD: begin
        if (sts_i.idx_end) begin
          if (sts_i.depth_zero) begin
            state_d = ST_P_TOP;
          end else begin
            cmd_o = CMD_S_POP;
          end
        end else begin
          cmd_o   = CMD_S_RD;
          state_d = ST_S_CHK;
        end
      end
      ST_S_CHK: begin
        if (sts_i.rd_zero) begin
          cmd_o   = CMD_S_SKIP;
          state_d = ST_S_RD;
        end else if (sts_i.leaf_depth) begin
          cmd_o   = CMD_S_LEAF;
          state_d = ST_S_RD;
        end else begin
          cmd_o   = CMD_S_PUSH;
          state_d = ST_E_RD;
        end
      end
      ST_E_RD: begin
        if (sts_i.cnt_end) begin
          if (!sts_i.avoid_hit) begin
            cmd_o   = CMD_E_TAKE;
            state_d = ST_P_INIT;
          end else begin
            state_d = ST_S_RD;
          end
        end else begin
          cmd_o   = CMD_E_RD;
          state_d = ST_E_CHK;
        end
      end
      ST_E_CHK: begin
        if (sts_i.rd_zero) begin
          cmd_o   = CMD_E_NEXT;
          state_d = ST_E_RD;
        end else begin
          state_d = ST_S_RD;
        end
      end
      ST_P_TOP: begin
        if (sts_i.top_small) begin
          cmd_o   = CMD_P_TOP;
          state_d = ST_P_INIT;
        end else begin
          cmd_o   = CMD_CNT_CLR;
          state_d = ST_V_RD;
        end
      end
      ST_V_RD: begin
        if (sts_i.cnt_end) begin
          cmd_o   = CMD_V_END;
          state_d = ST_P_INIT;
        end else begin
          cmd_o   = CMD_V_RD;
          state_d = ST_V_WR;
        end
      end
      ST_V_WR: begin
        cmd_o   = CMD_V_WR;
        state_d = ST_V_RD;
      end
      ST_P_INIT: begin
        cmd_o = CMD_CNT_CLR;
        if (sts_i.last_lvl) begin
          state_d = sts_i.swap_hit ? ST_R_RD : ST_LINK;
        end else begin
          state_d = ST_Z_WR;
        end
      end
      ST_Z_WR: begin
        if (sts_i.cnt_end) begin
          state_d = ST_LINK;
        end else begin
          cmd_o = CMD_Z_WR;
        end
      end
      ST_R_RD: begin
        if (sts_i.cnt_end) begin
          state_d = ST_LINK;
        end else begin
          cmd_o   = CMD_R_RD;
          state_d = ST_R_WR;
        end
      end
      ST_R_WR: begin
        cmd_o   = CMD_R_WR;
        state_d = ST_R_RD;
      end
      ST_LINK: begin
        cmd_o   = CMD_LINK;
        state_d = sts_i.last_lvl ? ST_ACC : ST_T_RD;
      end
      ST_ACC: begin
        cmd_o   = sts_i.is_write ? CMD_A_WR : CMD_A_RD;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o   = CMD_OUT;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/hptw_dpath.sv
`timescale 1ns / 1ps

module hptw_dpath import hptw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_e           cmd_i,
  input  logic              in_op_i,
  input  logic [ADDR_W-1:0] in_va_i,
  input  logic [DATA_W-1:0] in_wv_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              out_status_o,
  output logic [DATA_W-1:0] out_read_o,
  output logic [PA_W-1:0]   out_pa_o,
  output dp_sts_t           sts_o
);

  logic [WORD_BITS-1:0] fs_mem [FRAME_WORDS];
  logic [WORD_BITS-1:0] sw_mem [VIRT_WORDS];

  logic                  op_q;
  logic                  err_q;
  logic [VA_BITS-1:0]    va_q;
  logic [DATA_W-1:0]     wv_q;
  logic [LVL_BITS-1:0]   lvl_q;
  logic [WORD_BITS-1:0]  tcur_q;
  logic [WORD_BITS-1:0]  sframe_q;
  logic [CNT_BITS-1:0]   sidx_q;
  logic [PAGE_BITS-1:0]  prefix_q;
  logic [WORD_BITS-1:0]  stk_q [TABLE_LEVELS];
  logic [STK_BITS-1:0]   depth_q;
  logic [FA_BITS-1:0]    slot_q;
  logic [WORD_BITS-1:0]  top_q;
  logic [DIST_BITS-1:0]  bdist_q;
  logic [WORD_BITS-1:0]  bframe_q;
  logic [PAGE_BITS-1:0]  bpage_q;
  logic [FA_BITS-1:0]    bslot_q;
  logic [WORD_BITS-1:0]  pick_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [FA_BITS-1:0]    pa_q;
  logic [PAGE_COUNT-1:0] swap_vld_q;
  logic                  swap_hit_q;
  logic [PAGE_WORDS-1:0] root_vld_q;
  logic [WORD_BITS-1:0]  fs_q;
  logic                  fs_inv_q;
  logic [WORD_BITS-1:0]  sw_q;
  logic                  out_valid_q;
  logic                  out_status_q;
  logic [DATA_W-1:0]     out_read_q;
  logic [PA_W-1:0]       out_pa_q;

  logic [PAGE_BITS-1:0]   page_w;
  logic [OFFSET_BITS-1:0] off_w;
  logic [OFFSET_BITS-1:0] tidx_w;
  logic [FA_BITS-1:0]     t_addr, s_addr, e_addr, v_addr, p_addr, a_addr;
  logic [PAGE_BITS-1:0]   leaf_page;
  logic [PAGE_BITS-1:0]   diff_w;
  logic [DIST_BITS-1:0]   wrap_w, dist_w;
  logic [WORD_BITS-1:0]   fs_rdata;
  logic                   fs_we, fs_re, sw_we, sw_re;
  logic [FA_BITS-1:0]     fs_addr;
  logic [WORD_BITS-1:0]   fs_wdata;
  logic [VA_BITS-1:0]     sw_addr;

  assign page_w    = va_q[VA_BITS-1:OFFSET_BITS];
  assign off_w     = va_q[OFFSET_BITS-1:0];
  assign tidx_w    = OFFSET_BITS'(page_w >>
                     (OFFSET_BITS * (LVL_BITS'(TABLE_LEVELS - 1) - lvl_q)));
  assign t_addr    = {tcur_q[FRAME_BITS-1:0], tidx_w};
  assign s_addr    = {sframe_q[FRAME_BITS-1:0], sidx_q[OFFSET_BITS-1:0]};
  assign e_addr    = {sframe_q[FRAME_BITS-1:0], cnt_q[OFFSET_BITS-1:0]};
  assign v_addr    = {bframe_q[FRAME_BITS-1:0], cnt_q[OFFSET_BITS-1:0]};
  assign p_addr    = {pick_q[FRAME_BITS-1:0], cnt_q[OFFSET_BITS-1:0]};
  assign a_addr    = {tcur_q[FRAME_BITS-1:0], off_w};
  assign leaf_page = PAGE_BITS'({prefix_q, sidx_q[OFFSET_BITS-1:0]});
  assign diff_w    = (leaf_page > page_w) ? (leaf_page - page_w) : (page_w - leaf_page);
  assign wrap_w    = DIST_BITS'(PAGE_COUNT) - {1'b0, diff_w};
  assign dist_w    = (wrap_w < {1'b0, diff_w}) ? wrap_w : {1'b0, diff_w};
  // unwritten root words read as zero
  assign fs_rdata  = fs_inv_q ? '0 : fs_q;

  always_comb begin
    fs_we    = 1'b0;
    fs_re    = 1'b0;
    fs_addr  = t_addr;
    fs_wdata = '0;
    sw_we    = 1'b0;
    sw_re    = 1'b0;
    sw_addr  = {page_w, cnt_q[OFFSET_BITS-1:0]};
    case (cmd_i)
      CMD_T_RD: fs_re = 1'b1;
      CMD_S_RD: begin
        fs_re   = 1'b1;
        fs_addr = s_addr;
      end
      CMD_E_RD: begin
        fs_re   = 1'b1;
        fs_addr = e_addr;
      end
      CMD_E_TAKE: begin
        fs_we   = 1'b1;
        fs_addr = slot_q;
      end
      CMD_V_RD: begin
        fs_re   = 1'b1;
        fs_addr = v_addr;
      end
      CMD_V_WR: begin
        sw_we   = 1'b1;
        sw_addr = {bpage_q, cnt_q[OFFSET_BITS-1:0]};
      end
      CMD_V_END: begin
        fs_we   = 1'b1;
        fs_addr = bslot_q;
      end
      CMD_Z_WR: begin
        fs_we   = 1'b1;
        fs_addr = p_addr;
      end
      CMD_R_RD: sw_re = 1'b1;
      CMD_R_WR: begin
        fs_we    = 1'b1;
        fs_addr  = p_addr;
        fs_wdata = sw_q;
      end
      CMD_LINK: begin
        fs_we    = 1'b1;
        fs_wdata = pick_q;
      end
      CMD_A_WR: begin
        fs_we    = 1'b1;
        fs_addr  = a_addr;
        fs_wdata = WORD_BITS'($signed(wv_q));
      end
      CMD_A_RD: begin
        fs_re   = 1'b1;
        fs_addr = a_addr;
      end
      default: begin
        fs_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[fs_addr] <= fs_wdata;
    end
    if (fs_re) begin
      fs_q     <= fs_mem[fs_addr];
      fs_inv_q <= (fs_addr[FA_BITS-1:OFFSET_BITS] == '0) &&
                  !root_vld_q[fs_addr[OFFSET_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_we) begin
      sw_mem[sw_addr] <= fs_rdata;
    end
    if (sw_re) begin
      sw_q <= sw_mem[sw_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_vld_q  <= '0;
      swap_hit_q  <= 1'b0;
      root_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      swap_hit_q <= swap_vld_q[page_w];
      if (fs_we && (fs_addr[FA_BITS-1:OFFSET_BITS] == '0)) begin
        root_vld_q[fs_addr[OFFSET_BITS-1:0]] <= 1'b1;
      end
      if (cmd_i == CMD_V_END) begin
        swap_vld_q[bpage_q] <= 1'b1;
      end
      if (cmd_i == CMD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q   <= in_op_i;
        va_q   <= VA_BITS'(in_va_i);
        wv_q   <= in_wv_i;
        err_q  <= sts_o.in_oor;
        lvl_q  <= '0;
        tcur_q <= '0;
      end
      CMD_T_NEXT: begin
        tcur_q <= fs_rdata;
        lvl_q  <= lvl_q + 1'b1;
      end
      CMD_S_INIT: begin
        sframe_q <= '0;
        sidx_q   <= '0;
        prefix_q <= '0;
        depth_q  <= '0;
        top_q    <= '0;
        bdist_q  <= '0;
        bframe_q <= '0;
        bpage_q  <= '0;
        bslot_q  <= '0;
      end
      CMD_S_POP: begin
        depth_q  <= depth_q - 1'b1;
        sframe_q <= stk_q[depth_q - 1'b1];
        sidx_q   <= {1'b0, prefix_q[OFFSET_BITS-1:0]} + 1'b1;
        prefix_q <= prefix_q >> OFFSET_BITS;
      end
      CMD_S_SKIP: sidx_q <= sidx_q + 1'b1;
      CMD_S_LEAF: begin
        if (fs_rdata > top_q) begin
          top_q <= fs_rdata;
        end
        if (dist_w > bdist_q) begin
          bdist_q  <= dist_w;
          bframe_q <= fs_rdata;
          bpage_q  <= leaf_page;
          bslot_q  <= s_addr;
        end
        sidx_q <= sidx_q + 1'b1;
      end
      CMD_S_PUSH: begin
        if (fs_rdata > top_q) begin
          top_q <= fs_rdata;
        end
        stk_q[depth_q] <= sframe_q;
        prefix_q       <= PAGE_BITS'({prefix_q, sidx_q[OFFSET_BITS-1:0]});
        depth_q        <= depth_q + 1'b1;
        sframe_q       <= fs_rdata;
        sidx_q         <= '0;
        slot_q         <= s_addr;
        cnt_q          <= '0;
      end
      CMD_E_NEXT: cnt_q <= cnt_q + 1'b1;
      CMD_E_TAKE: pick_q <= sframe_q;
      CMD_P_TOP: begin
        pick_q <= top_q + 1'b1;
        cnt_q  <= '0;
      end
      CMD_CNT_CLR: cnt_q <= '0;
      CMD_V_WR:    cnt_q <= cnt_q + 1'b1;
      CMD_V_END:   pick_q <= bframe_q;
      CMD_Z_WR:    cnt_q <= cnt_q + 1'b1;
      CMD_R_WR:    cnt_q <= cnt_q + 1'b1;
      CMD_LINK: begin
        tcur_q <= pick_q;
        lvl_q  <= lvl_q + 1'b1;
      end
      CMD_A_WR: pa_q <= a_addr;
      CMD_A_RD: pa_q <= a_addr;
      CMD_OUT: begin
        out_status_q <= err_q;
        out_read_q   <= (err_q || op_q) ? '0 : DATA_W'(fs_rdata);
        out_pa_q     <= err_q ? '0 : PA_W'(pa_q);
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign sts_o.in_oor     = (in_va_i >> VA_BITS) != '0;
  assign sts_o.rd_zero    = fs_rdata == '0;
  assign sts_o.last_lvl   = lvl_q == LVL_BITS'(TABLE_LEVELS - 1);
  assign sts_o.idx_end    = sidx_q == CNT_BITS'(PAGE_WORDS);
  assign sts_o.cnt_end    = cnt_q == CNT_BITS'(PAGE_WORDS);
  assign sts_o.depth_zero = depth_q == '0;
  assign sts_o.leaf_depth = depth_q == STK_BITS'(TABLE_LEVELS - 1);
  assign sts_o.avoid_hit  = sframe_q == tcur_q;
  assign sts_o.top_small  = top_q < WORD_BITS'(FRAME_COUNT - 1);
  assign sts_o.swap_hit   = swap_hit_q;
  assign sts_o.is_write   = op_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_read_o   = out_read_q;
  assign out_pa_o     = out_pa_q;

endmodule

// File: rtl/hierarchical_page_table_walker_unit.sv
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                        tuser
// s_axis    in   virtual_address[31:0], write_value[63:32] op (0 read, 1 write)
// m_axis    out  read_value[31:0], physical_address[39:32] status (1 out of range)
//
// One beat at a time. A fault walks the table tree through the single frame-store
// port word by word, then copies a page word by word to evict or restore it, and
// writes a table word by word to zero it.
// Reset clears the root table through per-word valid bits; no clearing pass.
// A finished result waits in the output register while the next beat is taken.

module hierarchical_page_table_walker_unit import hptw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // virtual_address, write_value
  input  logic [0:0]           s_axis_tuser,  // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // read_value, physical_address
  output logic [0:0]           m_axis_tuser   // status
);

  dp_cmd_e           cmd;
  dp_sts_t           sts;
  logic              out_status;
  logic [DATA_W-1:0] out_read;
  logic [PA_W-1:0]   out_pa;

  hptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hptw_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_op_i      (s_axis_tuser[0]),
    .in_va_i      (s_axis_tdata[ADDR_W-1:0]),
    .in_wv_i      (s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_read_o   (out_read),
    .out_pa_o     (out_pa),
    .sts_o        (sts)
  );

  assign m_axis_tdata = {out_pa, out_read};
  assign m_axis_tuser = out_status;

endmodule
